[sv/ibmap_pkg.sv]
// ----------------------------------------------------------------------------
// ibmap_pkg
// Types and constants for the inode bitmap allocator: request and response
// payloads, command and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package ibmap_pkg;

  // fixed field widths of the request and response
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  // bitmap memory word layout
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // command codes
  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_TEST  = 2'd2
  } cmd_e;

  // status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_RESP
  } state_e;

  // request payload
  typedef struct packed {
    logic [1:0]         command;
    logic [INDEX_W-1:0] entry_index;
  } req_t;

  // response payload
  typedef struct packed {
    logic [INDEX_W-1:0] result_index;
    logic [1:0]         status;
    logic               entry_bit;
    logic [COUNT_W-1:0] allocated_count;
  } rsp_t;

endpackage

[sv/inode_bitmap_allocator_top.sv]
// ----------------------------------------------------------------------------
// inode_bitmap_allocator_top
// Next-fit bitmap allocator: allocate, free and test of in-use entries, with
// a search hint and a count of allocated entries.
// ----------------------------------------------------------------------------
// The bitmap lives in one synchronous memory of 32-bit words with a registered
// read port. One request is worked on at a time. Free and test read the memory
// at acceptance, then decide (a free that hits writes the word back), then
// load the output register once it is free. Allocate reads one word per cycle
// starting at the hint's word and stops at the first word with a clear bit
// or, with status full, at the last word; it scans at most ENTRIES/32 rounded
// up words. A new request is taken while a finished response still waits in
// the output register. After reset the bitmap is cleared one word per cycle,
// ENTRIES/32 rounded up to a power of two (at least 2) words, and no request
// is taken until then.
module inode_bitmap_allocator_top #(
  parameter int ENTRIES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ibmap_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ibmap_pkg::rsp_t out_rsp_o
);

  localparam int WORD_W     = ibmap_pkg::WORD_W;
  localparam int BIT_W      = ibmap_pkg::BIT_W;
  localparam int IDX_OUT_W  = ibmap_pkg::INDEX_W;
  localparam int CNT_OUT_W  = ibmap_pkg::COUNT_W;
  localparam int WORDS      = (ENTRIES + WORD_W - 1) / WORD_W;
  localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int DEPTH      = 1 << AW;
  localparam int IW         = AW + BIT_W;
  localparam int CW         = $clog2(ENTRIES + 1);
  localparam int LAST_WORD  = (ENTRIES - 1) / WORD_W;
  localparam int TAIL_BITS  = ENTRIES % WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK =
    (TAIL_BITS == 0) ? '0 : ~((WORD_W'(1) << TAIL_BITS) - WORD_W'(1));

  ibmap_pkg::state_e state_q, state_d;

  logic [AW-1:0]        clr_addr_q, clr_addr_d;
  logic [1:0]           cmd_q, cmd_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic                 in_range_q, in_range_d;
  logic [IDX_OUT_W-1:0] echo_q, echo_d;
  logic                 first_q, first_d;
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic [IW-1:0]        hint_q, hint_d;
  logic [CW-1:0]        count_q, count_d;
  ibmap_pkg::rsp_t      res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  ibmap_pkg::rsp_t      out_rsp_q, out_rsp_d;

  // bitmap memory
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  // scan datapath
  logic [WORD_W-1:0] low_mask;
  logic [WORD_W-1:0] tail_mask;
  logic [WORD_W-1:0] free_vec;
  logic [BIT_W-1:0]  pos;
  logic              alloc_hit;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // free bits of the word under scan, with bits below the hint and past the
  // last entry treated as in use
  always_comb begin
    low_mask  = first_q ? ((WORD_W'(1) << hint_q[BIT_W-1:0]) - WORD_W'(1)) : '0;
    tail_mask = (rd_addr_q == AW'(LAST_WORD)) ? TAIL_MASK : '0;
    free_vec  = ~(rdata_q | low_mask | tail_mask);
    alloc_hit = |free_vec;
    pos       = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        pos = BIT_W'(j);
      end
    end
  end

  // sequencer: next state, memory control and response
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    in_range_d  = in_range_q;
    echo_d      = echo_q;
    first_d     = first_q;
    rd_addr_d   = rd_addr_q;
    hint_d      = hint_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = rd_addr_q;

    unique case (state_q)
      // wipe the bitmap one word per cycle
      ibmap_pkg::S_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = ibmap_pkg::S_IDLE;
        end
      end

      // take a request and read its first word
      ibmap_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_d      = in_req_i.command;
          echo_d     = in_req_i.entry_index;
          in_range_d = 32'(in_req_i.entry_index) < ENTRIES;
          idx_d      = IW'(in_req_i.entry_index);
          first_d    = 1'b1;
          mem_re     = 1'b1;
          if (in_req_i.command == ibmap_pkg::CMD_ALLOC) begin
            mem_raddr = hint_q[IW-1:BIT_W];
          end else begin
            mem_raddr = idx_d[IW-1:BIT_W];
          end
          rd_addr_d = mem_raddr;
          state_d   = ibmap_pkg::S_LOOK;
        end
      end

      // word is in rdata_q: decide, write back, or read the next word
      ibmap_pkg::S_LOOK: begin
        res_d.result_index    = echo_q;
        res_d.status          = ibmap_pkg::ST_OK;
        res_d.entry_bit       = 1'b0;
        state_d               = ibmap_pkg::S_RESP;
        unique case (cmd_q)
          ibmap_pkg::CMD_ALLOC: begin
            if (alloc_hit) begin
              mem_we             = 1'b1;
              mem_waddr          = rd_addr_q;
              mem_wdata          = rdata_q | (WORD_W'(1) << pos);
              hint_d             = {rd_addr_q, pos};
              count_d            = count_q + 1'b1;
              res_d.result_index = IDX_OUT_W'({rd_addr_q, pos});
              res_d.entry_bit    = 1'b1;
            end else if (rd_addr_q == AW'(LAST_WORD)) begin
              res_d.status = ibmap_pkg::ST_FULL;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = rd_addr_q + 1'b1;
              rd_addr_d = mem_raddr;
              first_d   = 1'b0;
              state_d   = ibmap_pkg::S_LOOK;
            end
          end
          ibmap_pkg::CMD_FREE: begin
            if (in_range_q && rdata_q[idx_q[BIT_W-1:0]]) begin
              mem_we    = 1'b1;
              mem_waddr = rd_addr_q;
              mem_wdata = rdata_q & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
              count_d   = count_q - 1'b1;
              if (hint_q > idx_q) begin
                hint_d = idx_q;
              end
            end else begin
              res_d.status = ibmap_pkg::ST_NOT_ALLOC;
            end
          end
          ibmap_pkg::CMD_TEST: begin
            res_d.entry_bit = in_range_q && rdata_q[idx_q[BIT_W-1:0]];
          end
          default: begin
            // unused command code: echo only
          end
        endcase
        res_d.allocated_count = CNT_OUT_W'(count_d);
      end

      // hand the response to the output register once it is free
      ibmap_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = ibmap_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ibmap_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ibmap_pkg::S_CLEAR;
      clr_addr_q  <= '0;
      hint_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      hint_q      <= hint_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    in_range_q <= in_range_d;
    echo_q     <= echo_d;
    first_q    <= first_d;
    rd_addr_q  <= rd_addr_d;
    res_q      <= res_d;
    out_rsp_q  <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // checks

  // the count never exceeds the number of entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= ENTRIES)
    else $error("allocated count beyond entries");

  // a successful allocate raises the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ibmap_pkg::S_LOOK && cmd_q == ibmap_pkg::CMD_ALLOC && alloc_hit)
    |=> count_q == $past(count_q) + 1'b1)
    else $error("allocate did not raise the count");

  // the bitmap is written only by the clearing pass or a read-modify-write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ibmap_pkg::S_CLEAR || state_q == ibmap_pkg::S_LOOK))
    else $error("bitmap write outside clear or update");

  // a full or not-allocated response never reports a set bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != ibmap_pkg::ST_OK) |-> !out_rsp_o.entry_bit)
    else $error("error response with entry bit set");

endmodule

[tb/tb_inode_bitmap_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_inode_bitmap_allocator_top
// Self-checking bench for the next-fit bitmap allocator. A bit-accurate
// predictor tracks the in-use map, search hint and allocated count, and each
// response is compared field by field with the oldest predicted one. Stimulus
// covers directed corner cases, a growth phase, a fill to full, and churn,
// with random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_inode_bitmap_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES       = 1024;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_PCT      = 26;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;

  // command value with no enum member, which the block ignores
  localparam logic [1:0] CMD_NONE = 2'd3;

  // predictor of the allocator plus the queue of predicted responses
  class bitmap_scoreboard;
    bit                          in_use [ENTRIES];
    bit [ibmap_pkg::INDEX_W-1:0] hint;
    int unsigned                 used;
    ibmap_pkg::rsp_t             rsp_q [$];
    int                          errors;

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
    endtask

    // apply one request to the tracked state and return its response
    function ibmap_pkg::rsp_t predict_response(ibmap_pkg::req_t r);
      ibmap_pkg::rsp_t rsp;
      int   slot;
      int   idx;
      idx                 = r.entry_index;
      rsp.result_index    = r.entry_index;
      rsp.status          = ibmap_pkg::ST_OK;
      rsp.entry_bit       = 1'b0;
      case (r.command)
        ibmap_pkg::CMD_ALLOC: begin
          // next fit from the hint, no wrap
          slot = hint;
          while (slot < ENTRIES && in_use[slot]) slot++;
          if (slot < ENTRIES) begin
            in_use[slot]     = 1'b1;
            hint             = ibmap_pkg::INDEX_W'(slot);
            used++;
            rsp.result_index = ibmap_pkg::INDEX_W'(slot);
            rsp.entry_bit    = 1'b1;
          end else begin
            rsp.status = ibmap_pkg::ST_FULL;
          end
        end
        ibmap_pkg::CMD_FREE: begin
          if (idx < ENTRIES && in_use[idx]) begin
            in_use[idx] = 1'b0;
            if (used > 0) used--;
            if (hint > idx) hint = ibmap_pkg::INDEX_W'(idx);
          end else begin
            rsp.status = ibmap_pkg::ST_NOT_ALLOC;
          end
        end
        ibmap_pkg::CMD_TEST: begin
          if (idx < ENTRIES) rsp.entry_bit = in_use[idx];
        end
        default: ;
      endcase
      rsp.allocated_count = ibmap_pkg::COUNT_W'(used);
      return rsp;
    endfunction

    function void note_request(ibmap_pkg::req_t r);
      rsp_q.push_back(predict_response(r));
    endfunction

    task check_response(ibmap_pkg::rsp_t got);
      ibmap_pkg::rsp_t want;
      if (rsp_q.size() == 0) begin
        report($sformatf("response idx %0d st %0d bit %0d cnt %0d with no request waiting",
                         got.result_index, got.status, got.entry_bit, got.allocated_count));
        return;
      end
      want = rsp_q.pop_front();
      if (got.result_index !== want.result_index)
        report($sformatf("result_index %0d, expected %0d",
                         got.result_index, want.result_index));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.entry_bit !== want.entry_bit)
        report($sformatf("entry_bit %0d, expected %0d", got.entry_bit, want.entry_bit));
      if (got.allocated_count !== want.allocated_count)
        report($sformatf("allocated_count %0d, expected %0d",
                         got.allocated_count, want.allocated_count));
    endtask

    function int pending();
      return rsp_q.size();
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  ibmap_pkg::req_t in_req_i    = '0;
  logic            out_ready_i = 1'b0;
  logic            in_ready_o;
  logic            out_valid_o;
  ibmap_pkg::rsp_t out_rsp_o;

  bitmap_scoreboard sb = new();

  // no idling on either side while set
  bit steady       = 1'b0;
  // asks the receiver for one long hold-off
  bit hold_off_req = 1'b0;
  int stall_cycles = 0;

  inode_bitmap_allocator_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // clock
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // response side: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // response check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb_inode_bitmap_allocator_top: errors");
          $finish;
        end
      end
    end
  end

  function automatic ibmap_pkg::req_t mk_req(logic [1:0] cmd,
                                             logic [ibmap_pkg::INDEX_W-1:0] idx);
    ibmap_pkg::req_t r;
    r.command     = cmd;
    r.entry_index = idx;
    return r;
  endfunction

  function automatic logic [ibmap_pkg::INDEX_W-1:0] rand_index();
    return ibmap_pkg::INDEX_W'($urandom_range(ENTRIES - 1));
  endfunction

  // random entry that is currently in use, or any entry if none is
  function automatic logic [ibmap_pkg::INDEX_W-1:0] pick_used_index();
    int start;
    int j;
    if (sb.used == 0) return rand_index();
    start = $urandom_range(ENTRIES - 1);
    for (int k = 0; k < ENTRIES; k++) begin
      j = (start + k) % ENTRIES;
      if (sb.in_use[j]) return ibmap_pkg::INDEX_W'(j);
    end
    return rand_index();
  endfunction

  // mostly well-formed traffic: frees of used entries and allocates, some noise
  function automatic ibmap_pkg::req_t random_req(int free_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3)               return mk_req(CMD_NONE, rand_index());
    if (roll < 8)               return mk_req(ibmap_pkg::CMD_FREE, rand_index());
    if (roll < 23)
      return mk_req(ibmap_pkg::CMD_TEST,
                    $urandom_range(1) ? pick_used_index() : rand_index());
    if (roll < 23 + free_pct)   return mk_req(ibmap_pkg::CMD_FREE, pick_used_index());
    return mk_req(ibmap_pkg::CMD_ALLOC, rand_index());
  endfunction

  // offer one request and hold it until accepted
  task automatic send_req(input ibmap_pkg::req_t r);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // stop offering and wait for every outstanding response
  task automatic wait_all_responses();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty map, hole refill, double free, ignored command
    send_req(mk_req(ibmap_pkg::CMD_TEST, '0));
    send_req(mk_req(ibmap_pkg::CMD_FREE, '0));
    send_req(mk_req(ibmap_pkg::CMD_FREE, '1));
    send_req(mk_req(ibmap_pkg::CMD_ALLOC, '1));
    send_req(mk_req(ibmap_pkg::CMD_ALLOC, '0));
    send_req(mk_req(ibmap_pkg::CMD_ALLOC, 10'h155));
    send_req(mk_req(ibmap_pkg::CMD_TEST, 10'd1));
    send_req(mk_req(ibmap_pkg::CMD_TEST, '1));
    send_req(mk_req(ibmap_pkg::CMD_FREE, 10'd1));
    send_req(mk_req(ibmap_pkg::CMD_ALLOC, 10'h2AA));
    send_req(mk_req(ibmap_pkg::CMD_FREE, '0));
    send_req(mk_req(ibmap_pkg::CMD_FREE, '0));
    send_req(mk_req(CMD_NONE, 10'h2AA));
    send_req(mk_req(CMD_NONE, 10'h155));
    send_req(mk_req(ibmap_pkg::CMD_ALLOC, '0));
    send_req(mk_req(ibmap_pkg::CMD_TEST, '0));
    wait_all_responses();

    // growth: allocate-heavy, with a long hold-off and a stretch with no idling
    for (int n = 0; n < 120; n++) begin
      if (n == 20) hold_off_req = 1'b1;
      steady = (n >= 40 && n < 110);
      send_req(random_req(10));
    end
    steady = 1'b0;
    wait_all_responses();

    // fill the map completely while the receiver holds off at first
    hold_off_req = 1'b1;
    while (sb.used < ENTRIES) begin
      if ($urandom_range(19) == 0) begin
        send_req(mk_req(ibmap_pkg::CMD_TEST, pick_used_index()));
      end else begin
        send_req(mk_req(ibmap_pkg::CMD_ALLOC, rand_index()));
      end
    end

    // full map: allocates fail, top entry freed and taken again
    repeat (4) send_req(mk_req(ibmap_pkg::CMD_ALLOC, rand_index()));
    send_req(mk_req(ibmap_pkg::CMD_FREE, '1));
    send_req(mk_req(ibmap_pkg::CMD_FREE, '1));
    send_req(mk_req(ibmap_pkg::CMD_TEST, '1));
    send_req(mk_req(ibmap_pkg::CMD_ALLOC, '0));
    send_req(mk_req(ibmap_pkg::CMD_TEST, '1));
    send_req(mk_req(ibmap_pkg::CMD_ALLOC, '1));
    wait_all_responses();

    // churn: frees lower the hint and allocates refill the holes
    for (int n = 0; n < 120; n++) send_req(random_req(50));
    wait_all_responses();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d responses never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb_inode_bitmap_allocator_top: clean");
    end else begin
      $display("tb_inode_bitmap_allocator_top: errors");
    end
    $finish;
  end

endmodule
